FILE: src/bti_pkg.sv
`default_nettype none
package bti_pkg;

  localparam int MAX_NODES_DEF = 65536;
  localparam int ADDR_BITS_DEF = 128;
  localparam int V4_BITS       = 32;

  localparam int WIDX_W     = 17;
  localparam int WORD_W     = 32;
  localparam int HALF_W     = 64;
  localparam int STATUS_W   = 3;
  localparam int NCOUNT_W   = 17;
  localparam int START_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // command kinds decided by the front end
  localparam logic [1:0] K_LOAD  = 2'd0;
  localparam logic [1:0] K_WALK  = 2'd1;
  localparam logic [1:0] K_NO_V4 = 2'd2;
  localparam logic [1:0] K_NO_V6 = 2'd3;

  localparam logic [STATUS_W-1:0] ST_FOUND   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_DATA = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_V4   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_V6   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DB_ERR  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_NODES  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_V4_START   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_V4_SUP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_V6_SUP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_BYTES = 3'd4;

  typedef struct packed {
    logic [NCOUNT_W-1:0] num_nodes;
    logic [START_W-1:0]  v4_start_node;
    logic                v4_supported;
    logic                v6_supported;
    logic [WORD_W-1:0]   data_bytes;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [WIDX_W-1:0]  word_index;
    logic [WORD_W-1:0]  word_value;
    logic [START_W-1:0] start_node;
    logic               is_v6;
  } cmd_t;

endpackage
`default_nettype wire

FILE: src/bti_if.sv
`default_nettype none
interface bti_in_if;
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic [bti_pkg::WIDX_W-1:0]   word_index;
  logic [bti_pkg::WORD_W-1:0]   word_value;
  logic [bti_pkg::HALF_W-1:0]   addr_hi;
  logic [bti_pkg::HALF_W-1:0]   addr_lo;
  logic                         is_v6;

  modport source (output valid, mode, word_index, word_value, addr_hi, addr_lo, is_v6,
                  input ready);
  modport sink   (input valid, mode, word_index, word_value, addr_hi, addr_lo, is_v6,
                  output ready);
endinterface

interface bti_out_if;
  logic                           valid;
  logic                           ready;
  logic [bti_pkg::STATUS_W-1:0]   status;
  logic [bti_pkg::WORD_W-1:0]     record_offset;

  modport source (output valid, status, record_offset, input ready);
  modport sink   (input valid, status, record_offset, output ready);
endinterface
`default_nettype wire

FILE: src/binary_trie_ip_lookup.sv
`default_nettype none
// Binary trie longest-prefix lookup. Input transactions either load one 32-bit
// child word into the node store (mode 0) or look up an IPv4/IPv6 address
// (mode 1); each lookup returns exactly one status/offset transaction, loads
// return none. A front end classifies transactions into a two-entry queue; the
// back end owns the node store and performs the walk. A walk covers at most 32
// (IPv4) or ADDR_BITS (IPv6) address bits: it starts, takes one step per bit,
// sees that the walk is done and then forms the result; every bit is one
// dependent read of the node store, whose registered output feeds the next
// address directly. A result held in the output register stalls the back end
// only where it must give a result (a disabled family or the end of a walk);
// loads and walk steps go on. Configuration must be written while no lookup
// is outstanding; store words read before being written return unspecified
// data.
module binary_trie_ip_lookup #(
  parameter int MAX_NODES = bti_pkg::MAX_NODES_DEF,
  parameter int ADDR_BITS = bti_pkg::ADDR_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  bti_in_if.sink                                 in_ch,
  bti_out_if.source                              out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [bti_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [bti_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import bti_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  cmd_t                 q_cmd;
  logic [ADDR_BITS-1:0] q_addr;
  logic                 q_valid, q_ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_NUM_NODES:  cfg_nxt.num_nodes     = cfg_wdata[NCOUNT_W-1:0];
        REG_V4_START:   cfg_nxt.v4_start_node = cfg_wdata[START_W-1:0];
        REG_V4_SUP:     cfg_nxt.v4_supported  = cfg_wdata[0];
        REG_V6_SUP:     cfg_nxt.v6_supported  = cfg_wdata[0];
        REG_DATA_BYTES: cfg_nxt.data_bytes    = cfg_wdata[WORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  bti_front #(
    .ADDR_BITS (ADDR_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_cmd   (q_cmd),
    .q_addr  (q_addr)
  );

  bti_back #(
    .MAX_NODES (MAX_NODES),
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_cmd   (q_cmd),
    .q_addr  (q_addr),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire

FILE: src/bti_front.sv
`default_nettype none
module bti_front #(
  parameter int ADDR_BITS = bti_pkg::ADDR_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  bti_in_if.sink                     in_ch,
  input  wire bti_pkg::cfg_t         cfg,
  output logic                       q_valid,
  input  wire logic                  q_ready,
  output bti_pkg::cmd_t              q_cmd,
  output logic [ADDR_BITS-1:0]       q_addr
);
  import bti_pkg::*;

  cmd_t                 cmd_in;
  logic [ADDR_BITS-1:0] addr_in;
  logic [2*HALF_W-1:0]  full_addr;
  logic [ADDR_BITS-1:0] v4_vec;
  logic                 push, pop;

  cmd_t                 cmd_r  [2];
  logic [ADDR_BITS-1:0] addr_r [2];
  logic                 wr_ptr_r, wr_ptr_nxt;
  logic                 rd_ptr_r, rd_ptr_nxt;
  logic [1:0]           cnt_r, cnt_nxt;

  // classify: load, walk, or a family that is switched off
  always_comb begin
    full_addr = {in_ch.addr_hi, in_ch.addr_lo};
    v4_vec    = ADDR_BITS'(in_ch.addr_lo[V4_BITS-1:0]) << (ADDR_BITS - V4_BITS);
    addr_in   = in_ch.is_v6 ? full_addr[2*HALF_W-1 -: ADDR_BITS] : v4_vec;
    cmd_in.word_index = in_ch.word_index;
    cmd_in.word_value = in_ch.word_value;
    cmd_in.start_node = in_ch.is_v6 ? '0 : cfg.v4_start_node;
    cmd_in.is_v6      = in_ch.is_v6;
    priority if (!in_ch.mode) begin
      cmd_in.kind = K_LOAD;
    end else if (!in_ch.is_v6 && !cfg.v4_supported) begin
      cmd_in.kind = K_NO_V4;
    end else if (in_ch.is_v6 && !cfg.v6_supported) begin
      cmd_in.kind = K_NO_V6;
    end else begin
      cmd_in.kind = K_WALK;
    end
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != 2'd0);
  assign pop         = q_valid && q_ready;
  assign q_cmd       = cmd_r[rd_ptr_r];
  assign q_addr      = addr_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      cmd_r[wr_ptr_r]  <= cmd_in;
      addr_r[wr_ptr_r] <= addr_in;
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("queue count out of range");
  a_full_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !pop) |=> cnt_r == 2'd2)
    else $error("queue lost an entry while full");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd1) |-> (wr_ptr_r != rd_ptr_r))
    else $error("queue pointers disagree with count");
`endif

endmodule
`default_nettype wire

FILE: src/bti_back.sv
`default_nettype none
module bti_back #(
  parameter int MAX_NODES = bti_pkg::MAX_NODES_DEF,
  parameter int ADDR_BITS = bti_pkg::ADDR_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire bti_pkg::cfg_t         cfg,
  input  wire logic                  q_valid,
  output logic                       q_ready,
  input  wire bti_pkg::cmd_t         q_cmd,
  input  wire logic [ADDR_BITS-1:0]  q_addr,
  bti_out_if.source                  out_ch
);
  import bti_pkg::*;

  localparam int              StoreWordsInt = 2 * MAX_NODES;
  localparam logic [31:0]     StoreWords    = 32'(StoreWordsInt);
  localparam int              IW            = $clog2(StoreWordsInt);
  localparam int              CW            = $clog2(ADDR_BITS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [WORD_W-1:0] mem [StoreWordsInt];
  logic [WORD_W-1:0] rd_q;
  logic [IW-1:0]     rd_addr, wr_addr;
  logic              mem_we;

  logic [1:0]            state_r, state_nxt;
  logic [WORD_W-1:0]     node_r, node_nxt;
  logic [ADDR_BITS-1:0]  addr_sh_r, addr_sh_nxt;
  logic [CW-1:0]         bits_r, bits_nxt;
  logic                  use_mem_r, use_mem_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [WORD_W-1:0]     out_offset_r, out_offset_nxt;

  logic [WORD_W-1:0]     cur;
  logic                  cur_leaf;
  logic [NCOUNT_W:0]     idx;
  logic [31:0]           idx32, widx32;
  logic                  idx_ok, wr_ok, res_free;
  logic [WORD_W+1:0]     offset;

  always_comb begin
    // the current node comes from the store right after a read was issued
    cur      = use_mem_r ? rd_q : node_r;
    cur_leaf = cur > {{(WORD_W-NCOUNT_W){1'b0}}, cfg.num_nodes};
    idx      = {cur[NCOUNT_W-1:0], addr_sh_r[ADDR_BITS-1]};
    idx32    = {{(32-NCOUNT_W-1){1'b0}}, idx};
    idx_ok   = idx32 < StoreWords;
    rd_addr  = idx32[IW-1:0];
    widx32   = {{(32-WIDX_W){1'b0}}, q_cmd.word_index};
    wr_ok    = widx32 < StoreWords;
    wr_addr  = widx32[IW-1:0];
    res_free = !out_valid_r || out_ch.ready;
    // node + 7 * num_nodes, with node above num_nodes so no underflow
    offset   = {2'b00, node_r}
             + {{(WORD_W+2-NCOUNT_W-3){1'b0}}, cfg.num_nodes, 3'b000}
             - {{(WORD_W+2-NCOUNT_W){1'b0}}, cfg.num_nodes};
  end

  always_comb begin
    state_nxt      = state_r;
    node_nxt       = node_r;
    addr_sh_nxt    = addr_sh_r;
    bits_nxt       = bits_r;
    use_mem_nxt    = use_mem_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_offset_nxt = out_offset_r;
    q_ready        = 1'b0;
    mem_we         = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          unique case (q_cmd.kind)
            K_LOAD: begin
              q_ready = 1'b1;
              mem_we  = wr_ok;
            end
            K_WALK: begin
              q_ready     = 1'b1;
              node_nxt    = {{(WORD_W-START_W){1'b0}}, q_cmd.start_node};
              addr_sh_nxt = q_addr;
              bits_nxt    = q_cmd.is_v6 ? CW'(ADDR_BITS) : CW'(V4_BITS);
              use_mem_nxt = 1'b0;
              state_nxt   = S_WALK;
            end
            K_NO_V4, K_NO_V6: begin
              if (res_free) begin
                q_ready        = 1'b1;
                out_valid_nxt  = 1'b1;
                out_status_nxt = (q_cmd.kind == K_NO_V4) ? ST_NO_V4 : ST_NO_V6;
                out_offset_nxt = '0;
              end
            end
            default: ;
          endcase
        end
      end
      S_WALK: begin
        if (bits_r == '0 || cur_leaf) begin
          node_nxt    = cur;
          use_mem_nxt = 1'b0;
          state_nxt   = S_FIN;
        end else begin
          addr_sh_nxt = addr_sh_r << 1;
          bits_nxt    = bits_r - CW'(1);
          if (idx_ok) begin
            use_mem_nxt = 1'b1;
          end else begin
            node_nxt    = '0;
            use_mem_nxt = 1'b0;
          end
        end
      end
      S_FIN: begin
        if (res_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          priority if (node_r <= {{(WORD_W-NCOUNT_W){1'b0}}, cfg.num_nodes}) begin
            out_status_nxt = ST_NO_DATA;
            out_offset_nxt = '0;
          end else if (offset >= {2'b00, cfg.data_bytes}) begin
            out_status_nxt = ST_DB_ERR;
            out_offset_nxt = '0;
          end else begin
            out_status_nxt = ST_FOUND;
            out_offset_nxt = offset[WORD_W-1:0];
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      use_mem_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      use_mem_r   <= use_mem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_r       <= node_nxt;
    addr_sh_r    <= addr_sh_nxt;
    bits_r       <= bits_nxt;
    out_status_r <= out_status_nxt;
    out_offset_r <= out_offset_nxt;
  end

  // node store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= q_cmd.word_value;
    end
    rd_q <= mem[rd_addr];
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.record_offset = out_offset_r;

`ifndef SYNTHESIS
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !q_ready)
    else $error("queue popped while a walk is in progress");
  a_mem_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    use_mem_r |-> ($past(state_r) == S_WALK && state_r == S_WALK))
    else $error("store data used without a read in the previous cycle");
  a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_FOUND) |-> out_offset_r == '0)
    else $error("nonzero offset on a miss");
  a_offset_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_FOUND) |-> out_offset_r < cfg.data_bytes)
    else $error("found offset beyond data section");
`endif

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bti_pkg::*;

  localparam int STORE_WORDS   = 2 * MAX_NODES_DEF;
  localparam int ITEMS_TARGET  = 1900;
  localparam int SETTLE_CYCLES = ADDR_BITS_DEF + 8;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  // indexes past the register list; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;

  typedef struct packed {
    logic              mode;
    logic [WIDX_W-1:0] word_index;
    logic [WORD_W-1:0] word_value;
    logic [HALF_W-1:0] addr_hi;
    logic [HALF_W-1:0] addr_lo;
    logic              is_v6;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   record_offset;
  } resp_t;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bti_in_if  in_ch();
  bti_out_if out_ch();

  binary_trie_ip_lookup uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // mirror of the block's state
  cfg_t              regs = '0;
  logic [WORD_W-1:0] node_words [STORE_WORDS];
  bit                word_loaded [STORE_WORDS];

  resp_t lookups_pending[$];
  int    bad_results = 0;
  int    sent_items = 0;

  bit tx_fast = 0;
  bit rx_fast = 0;
  bit rx_hold = 0;
  int rx_wait = 0;

  // current random trie: nodes 0..trie_top are fully loaded
  int trie_top = 0;
  int p_branch = 50;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic resp_t trie_lookup(input req_t r, output bit reads_blank);
    resp_t res;
    logic [127:0] addr;
    logic [63:0] node, idx, cnt, offset, limit;
    int nbits;
    reads_blank = 0;
    res.status = ST_FOUND;
    res.record_offset = '0;
    if (!r.is_v6 && !regs.v4_supported) begin
      res.status = ST_NO_V4;
      return res;
    end
    if (r.is_v6 && !regs.v6_supported) begin
      res.status = ST_NO_V6;
      return res;
    end
    cnt = 64'(regs.num_nodes);
    limit = 64'(regs.data_bytes);
    addr = r.is_v6 ? {r.addr_hi, r.addr_lo} : {96'd0, r.addr_lo[31:0]};
    nbits = r.is_v6 ? ADDR_BITS_DEF : V4_BITS;
    node = r.is_v6 ? 64'd0 : {48'd0, regs.v4_start_node};
    for (int i = 0; i < nbits; i++) begin
      if (node > cnt) break;
      idx = node * 2 + addr[nbits-1-i];
      if (idx >= STORE_WORDS) begin
        node = 64'd0;
      end else begin
        if (!word_loaded[idx]) reads_blank = 1;
        node = {32'd0, node_words[idx]};
      end
    end
    if (node <= cnt) begin
      res.status = ST_NO_DATA;
    end else begin
      // 64-bit math: a huge child must not wrap below the bound
      offset = node - cnt + cnt * 8;
      if (offset >= limit) res.status = ST_DB_ERR;
      else res.record_offset = offset[31:0];
    end
    return res;
  endfunction

  function automatic req_t any_req();
    req_t r;
    r.mode       = 1'($urandom_range(0, 1));
    r.word_index = WIDX_W'($urandom_range(0, STORE_WORDS - 1));
    r.word_value = $urandom;
    r.addr_hi    = {$urandom, $urandom};
    r.addr_lo    = {$urandom, $urandom};
    r.is_v6      = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] child_value();
    int x;
    x = $urandom_range(0, 99);
    if (x < p_branch) return $urandom_range(0, trie_top);
    if (x < p_branch + (100 - p_branch) * 3 / 4) return trie_top + 1 + $urandom_range(0, 40);
    return $urandom;
  endfunction

  task automatic issue(input req_t r);
    int gap;
    bit blank;
    gap = tx_fast ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= r.mode;
    in_ch.word_index <= r.word_index;
    in_ch.word_value <= r.word_value;
    in_ch.addr_hi    <= r.addr_hi;
    in_ch.addr_lo    <= r.addr_lo;
    in_ch.is_v6      <= r.is_v6;
    do @(posedge clk); while (!in_ch.ready);
    if (r.mode == MODE_LOAD) begin
      node_words[r.word_index] = r.word_value;
      word_loaded[r.word_index] = 1;
    end else begin
      lookups_pending.push_back(trie_lookup(r, blank));
    end
    sent_items++;
  endtask

  task automatic load_word(input int idx, input logic [WORD_W-1:0] val);
    req_t r;
    r = any_req();
    r.mode = MODE_LOAD;
    r.word_index = WIDX_W'(idx);
    r.word_value = val;
    issue(r);
  endtask

  task automatic lookup(input logic v6, input logic [63:0] hi, input logic [63:0] lo);
    req_t r;
    r = any_req();
    r.mode = MODE_LOOKUP;
    r.is_v6 = v6;
    r.addr_hi = hi;
    r.addr_lo = lo;
    issue(r);
  endtask

  task automatic await_idle();
    in_ch.valid <= 1'b0;
    while (lookups_pending.size() != 0) @(posedge clk);
    // loads give no result, so let the last one retire
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] i, input logic [CFG_DATA_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= i;
    cfg_wdata <= d;
    @(posedge clk);
    case (i)
      REG_NUM_NODES:  regs.num_nodes     = d[NCOUNT_W-1:0];
      REG_V4_START:   regs.v4_start_node = d[START_W-1:0];
      REG_V4_SUP:     regs.v4_supported  = d[0];
      REG_V6_SUP:     regs.v6_supported  = d[0];
      REG_DATA_BYTES: regs.data_bytes    = d;
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [NCOUNT_W-1:0] count, input logic [START_W-1:0] start,
                          input logic v4, input logic v6, input logic [WORD_W-1:0] bytes);
    await_idle();
    write_reg(REG_NUM_NODES, CFG_DATA_W'(count));
    write_reg(REG_V4_START, CFG_DATA_W'(start));
    write_reg(REG_V4_SUP, CFG_DATA_W'(v4));
    write_reg(REG_V6_SUP, CFG_DATA_W'(v6));
    write_reg(REG_DATA_BYTES, bytes);
    write_reg(CFG_IDX_W'(REG_SPARE_FIRST + $urandom_range(0, 2)), $urandom);
    cfg_we <= 1'b0;
  endtask

  task automatic send_random_lookup();
    req_t r;
    resp_t res;
    bit blank;
    for (int k = 0; k < 16; k++) begin
      r = any_req();
      r.mode = MODE_LOOKUP;
      res = trie_lookup(r, blank);
      if (!blank) begin
        issue(r);
        return;
      end
    end
  endtask

  task automatic send_random_load();
    req_t r;
    r = any_req();
    r.mode = MODE_LOAD;
    // mostly rewrite the live trie, sometimes scribble anywhere
    if ($urandom_range(0, 2) != 0) begin
      r.word_index = WIDX_W'($urandom_range(0, 2 * trie_top + 1));
      r.word_value = child_value();
    end
    issue(r);
  endtask

  // reset values leave both families disabled
  task automatic test_disabled_families();
    lookup(1'b0, '1, '1);
    lookup(1'b1, '1, '1);
  endtask

  // node0=[1,2] node1=[3,max] node2=[4,5] node3=[0,6]; offsets 25..27, bound 27
  task automatic test_small_trie();
    set_regs(3, 1, 1'b1, 1'b1, 27);
    load_word(0, 1);
    load_word(1, 2);
    load_word(2, 3);
    load_word(3, 32'hFFFF_FFFF);
    load_word(4, 4);
    load_word(5, 5);
    load_word(6, 0);
    load_word(7, 6);
    lookup(1'b1, 64'd0, 64'd0);
    lookup(1'b1, 64'h8000_0000_0000_0000, 64'd0);
    lookup(1'b1, 64'hC000_0000_0000_0000, 64'd0);
    lookup(1'b1, 64'h4000_0000_0000_0000, 64'd0);
    lookup(1'b1, 64'd0, '1);
    lookup(1'b0, 64'd0, 64'hFFFF_FFFF_4000_0000);
    lookup(1'b0, '1, 64'd0);
  endtask

  task automatic test_empty_trie();
    set_regs(0, 0, 1'b1, 1'b1, 0);
    load_word(0, 0);
    load_word(1, 1);
    lookup(1'b1, '1, '1);
    lookup(1'b0, 64'd0, 64'd0);
  endtask

  // top node count: walks pass through the node just past the store
  task automatic test_full_count();
    set_regs(MAX_NODES_DEF, 16'hFFFF, 1'b1, 1'b1, 32'hFFFF_FFFF);
    load_word(STORE_WORDS - 2, MAX_NODES_DEF);
    load_word(STORE_WORDS - 1, 32'hFFFF_FFFF);
    load_word(0, MAX_NODES_DEF);
    load_word(1, 70000);
    lookup(1'b0, '1, 64'h0000_0000_2000_0000);
    lookup(1'b0, 64'd0, 64'h0000_0000_8000_0000);
    lookup(1'b1, 64'h8000_0000_0000_0000, 64'd0);
    lookup(1'b1, 64'd0, 64'd0);
  endtask

  task automatic test_random_tries();
    logic [WORD_W-1:0] bytes;
    logic [START_W-1:0] start;
    while (sent_items < ITEMS_TARGET) begin
      trie_top = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 40);
      p_branch = $urandom_range(30, 95);
      start = START_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                                   : $urandom_range(0, trie_top));
      case ($urandom_range(0, 3))
        0: bytes = 0;
        1: bytes = 32'hFFFF_FFFF;
        2: bytes = 8 * trie_top + $urandom_range(0, 40);
        default: bytes = $urandom;
      endcase
      set_regs(NCOUNT_W'(trie_top), start, $urandom_range(0, 7) != 0,
               $urandom_range(0, 7) != 0, bytes);
      tx_fast = ($urandom_range(0, 3) == 0);
      rx_fast = ($urandom_range(0, 3) == 0);
      for (int w = 0; w <= 2 * trie_top + 1; w++) load_word(w, child_value());
      repeat (150) begin
        if ($urandom_range(0, 99) < 85) send_random_lookup();
        else send_random_load();
      end
    end
    tx_fast = 0;
    rx_fast = 0;
  endtask

  task automatic test_backpressure();
    tx_fast = 1;
    fork
      begin
        @(negedge clk) rx_hold = 1;
        repeat (300) @(negedge clk);
        rx_hold = 0;
      end
    join_none
    repeat (30) send_random_lookup();
    await_idle();
    rx_fast = 1;
    repeat (40) send_random_lookup();
    await_idle();
    tx_fast = 0;
    rx_fast = 0;
  endtask

  // result side: random stall after each transaction, plus the long hold
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) rx_wait = rx_fast ? 0 : $urandom_range(0, 14);
      if (!rst_n || rx_hold) begin
        out_ch.ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    resp_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (lookups_pending.size() == 0) begin
        if (bad_results < 10)
          $display("unexpected result: status %0d offset %0h", out_ch.status,
                   out_ch.record_offset);
        bad_results++;
      end else begin
        want = lookups_pending.pop_front();
        if (out_ch.status !== want.status || out_ch.record_offset !== want.record_offset) begin
          if (bad_results < 10)
            $display("mismatch: expected status %0d offset %0h, got status %0d offset %0h",
                     want.status, want.record_offset, out_ch.status, out_ch.record_offset);
          bad_results++;
        end
      end
    end
  end

  initial begin
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= '0;
    cfg_wdata        <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.mode       <= MODE_LOAD;
    in_ch.word_index <= '0;
    in_ch.word_value <= '0;
    in_ch.addr_hi    <= '0;
    in_ch.addr_lo    <= '0;
    in_ch.is_v6      <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_disabled_families();
    test_small_trie();
    test_empty_trie();
    test_full_count();
    test_random_tries();
    test_backpressure();
    await_idle();

    if (bad_results == 0 && lookups_pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
